// ----- sv/recent_key_set_fifo_evict_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the recent key set unit
// ---------------------------------------------------------------------------
`ifndef RECENT_KEY_SET_FIFO_EVICT_UNIT_MACROS_SVH
`define RECENT_KEY_SET_FIFO_EVICT_UNIT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define RKSE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form: block clock and reset
`define RKSE_ASSERT(lbl, prop, msg) \
  `RKSE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/rkse_pkg.sv -----
// ---------------------------------------------------------------------------
// rkse_pkg
// Commands, sequencer states and the fixed key field width of the recent key set.
// ---------------------------------------------------------------------------
package rkse_pkg;

  // Width of the key field on the port
  localparam int unsigned KeyFieldW = 48;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_WR = 6'b010000,
    S_WR    = 6'b100000
  } state_e;

endpackage

// ----- sv/recent_key_set_fifo_evict_unit.sv -----
// ---------------------------------------------------------------------------
// recent_key_set_fifo_evict_unit
// Ordered set of recent keys, oldest first, with FIFO eviction. One shared
// key comparator and one key memory (one write port, one read port) are stepped by a small sequencer.
// ---------------------------------------------------------------------------
//  Channel   Signals                          Direction  Handshake
//  command   start, busy, command_i,          in         start && !busy
//            key_value_i
//  result    done_o, found_o                  out        done_o, one cycle
//
//  Busy steps: a clear is never busy; others alternate S_RD and S_CMP per
//  entry compared, a miss ending in S_RD; a delete hit or full append then
//  alternates S_SH_RD and S_SH_WR per entry moved, ending in S_SH_RD; an
//  append miss adds the S_WR tail write. The result beat is the first cycle
//  with busy low again (for a clear, the cycle after the accept).
//  Reset clears the count and the sequencer; key storage is not cleared.
//  busy is high from the accepting edge of a non-clear command until the
//  edge that starts its result beat; a clear leaves busy low.
//  The receiver cannot stall; each result beat lasts exactly one cycle.
// ---------------------------------------------------------------------------
`include "recent_key_set_fifo_evict_unit_macros.svh"

module recent_key_set_fifo_evict_unit #(
  parameter int unsigned ENTRIES  = 10,
  parameter int unsigned KEY_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [47:0] key_value_i,
  output logic        done_o,
  output logic        found_o
);

  localparam int unsigned KW = (KEY_BITS < rkse_pkg::KeyFieldW) ? KEY_BITS
                                                                : rkse_pkg::KeyFieldW;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [CW-1:0] FullCnt = CW'(ENTRIES);

  rkse_pkg::state_e state_q, state_d;
  rkse_pkg::cmd_e   cmd_q, cmd_d;
  logic [KW-1:0]    key_q, key_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             hit_q, hit_d;
  logic             done_q, done_d;
  logic             found_q, found_d;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [KW-1:0]    mem_wdata;
  logic [IW-1:0]    mem_raddr;
  logic [KW-1:0]    mem_rdata;

  logic             key_eq;
  logic             search_end;
  logic             search_hit;
  logic [CW-1:0]    idx_inc;

  // Shared key comparator
  assign key_eq  = (mem_rdata == key_q);
  assign idx_inc = idx_q + CW'(1);

  rkse_keymem #(
    .Depth (ENTRIES),
    .Width (KW),
    .AddrW (IW)
  ) u_keymem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    count_d    = count_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    done_d     = 1'b0;
    found_d    = found_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[IW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_q[IW-1:0];
    search_end = 1'b0;
    search_hit = 1'b0;

    unique case (state_q)
      rkse_pkg::S_IDLE: begin
        if (start) begin
          cmd_d = rkse_pkg::cmd_e'(command_i);
          key_d = key_value_i[KW-1:0];
          idx_d = '0;
          if (rkse_pkg::cmd_e'(command_i) == rkse_pkg::CMD_CLEAR) begin
            count_d = '0;
            done_d  = 1'b1;
            found_d = 1'b1;
          end else begin
            state_d = rkse_pkg::S_RD;
          end
        end
      end
      rkse_pkg::S_RD: begin
        // End of valid entries: miss
        if (idx_q == count_q) begin
          search_end = 1'b1;
        end else begin
          state_d = rkse_pkg::S_CMP;
        end
      end
      rkse_pkg::S_CMP: begin
        if (key_eq) begin
          search_end = 1'b1;
          search_hit = 1'b1;
        end else begin
          idx_d   = idx_inc;
          state_d = rkse_pkg::S_RD;
        end
      end
      rkse_pkg::S_SH_RD: begin
        // Read the next entry, or finish the compaction
        mem_raddr = idx_inc[IW-1:0];
        if (idx_inc >= count_q) begin
          count_d = count_q - CW'(1);
          if (cmd_q == rkse_pkg::CMD_APPEND) begin
            state_d = rkse_pkg::S_WR;
          end else begin
            state_d = rkse_pkg::S_IDLE;
            done_d  = 1'b1;
            found_d = hit_q;
          end
        end else begin
          state_d = rkse_pkg::S_SH_WR;
        end
      end
      rkse_pkg::S_SH_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = rkse_pkg::S_SH_RD;
      end
      rkse_pkg::S_WR: begin
        // Store new key at the tail
        mem_we    = 1'b1;
        mem_waddr = count_q[IW-1:0];
        mem_wdata = key_q;
        count_d   = count_q + CW'(1);
        state_d   = rkse_pkg::S_IDLE;
        done_d    = 1'b1;
        found_d   = 1'b0;
      end
      default: begin
        state_d = rkse_pkg::S_IDLE;
      end
    endcase

    // Dispatch once the search is over
    if (search_end) begin
      hit_d = search_hit;
      case (cmd_q)
        rkse_pkg::CMD_APPEND: begin
          if (search_hit) begin
            state_d = rkse_pkg::S_IDLE;
            done_d  = 1'b1;
            found_d = 1'b1;
          end else if (count_q >= FullCnt) begin
            idx_d   = '0;
            state_d = rkse_pkg::S_SH_RD;
          end else begin
            state_d = rkse_pkg::S_WR;
          end
        end
        rkse_pkg::CMD_DELETE: begin
          if (search_hit) begin
            state_d = rkse_pkg::S_SH_RD;
          end else begin
            state_d = rkse_pkg::S_IDLE;
            done_d  = 1'b1;
            found_d = 1'b0;
          end
        end
        default: begin
          state_d = rkse_pkg::S_IDLE;
          done_d  = 1'b1;
          found_d = search_hit;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rkse_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    found_q <= found_d;
  end

  assign busy    = (state_q != rkse_pkg::S_IDLE);
  assign done_o  = done_q;
  assign found_o = found_q;

  // Checks
  `RKSE_ASSERT(a_count_range, count_q <= FullCnt, "key count above capacity")
  `RKSE_ASSERT(a_done_idle, done_o |-> !busy, "result beat while still busy")
  `RKSE_ASSERT(a_clear_resp,
               (start && !busy && command_i == rkse_pkg::CMD_CLEAR) |=> (done_o && found_o),
               "clear did not report found in the next cycle")
  `RKSE_ASSERT(a_cmp_after_rd, (state_q == rkse_pkg::S_CMP) |-> ($past(state_q) == rkse_pkg::S_RD),
               "compare step without a preceding read")

endmodule

// ----- sv/rkse_keymem.sv -----
// ---------------------------------------------------------------------------
// rkse_keymem
// Key storage: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rkse_keymem #(
  parameter int unsigned Depth = 10,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
